// ===== src/sync_length_xor_deframer_macros.svh =====
// ----------------------------------------------------------------------------
// sync_length_xor_deframer assertion macros
// Shared property wrappers; every check uses clk and is off during rst_n low.
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_XOR_DEFRAMER_MACROS_SVH
`define SYNC_LENGTH_XOR_DEFRAMER_MACROS_SVH

// Same-cycle implication.
`define SLD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SLD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sld_pkg.sv =====
// ----------------------------------------------------------------------------
// sld_pkg
// Types and constants shared by the deframer front end, queue and back end.
// ----------------------------------------------------------------------------
package sld_pkg;

  // Length counters cover the full range of the payload limit (up to 64).
  localparam int LEN_W = 7;

  localparam logic [7:0] SYNC_RESET = 8'd164;
  localparam logic [7:0] LEN_SAT_BYTE = 8'd63;
  localparam logic [5:0] PLEN_SAT = 6'd63;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN,
    PH_ID,
    PH_DATA,
    PH_CHECK
  } phase_t;

  typedef enum logic [1:0] {
    ST_DATA    = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_BADSUM  = 2'd2,
    ST_TOOLONG = 2'd3
  } status_t;

  // One frame outcome handed from the front end to the back end.
  typedef struct packed {
    status_t            status;
    logic [7:0]         id;
    logic [5:0]         plen;
    logic [LEN_W-1:0]   len;
    logic               bank;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Payload bank released by the back end after its last read.
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

endpackage

// ===== src/sld_ram.sv =====
// ----------------------------------------------------------------------------
// sld_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read port, hold data while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/sld_front.sv =====
// ----------------------------------------------------------------------------
// sld_front
// Frame parser: hunts for sync, tracks length, id and running XOR, writes
// payload beats into a free RAM bank and posts one outcome per frame.
// ----------------------------------------------------------------------------
`include "sync_length_xor_deframer_macros.svh"

module sld_front #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic [7:0]                      cfg_sync_value,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_rx_byte,
  output logic                            cmd_push,
  output sld_pkg::cmd_t                   cmd,
  input  sld_pkg::q_stat_t                q_stat,
  input  sld_pkg::bank_rel_t              rel,
  output logic                            ram_we,
  output logic [$clog2(MAX_PAYLOAD):0]    ram_waddr,
  output logic [7:0]                      ram_wdata
);

  import sld_pkg::*;

  localparam int AW = $clog2(MAX_PAYLOAD);

  phase_t           phase_r, phase_nxt;
  logic [7:0]       sync_r;
  logic [7:0]       xor_r;
  logic [7:0]       id_r;
  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] taken_r;
  logic             wbank_r;
  logic [1:0]       busy_r;
  logic [1:0]       busy_nxt;

  logic             accept;
  logic             too_long;
  logic             sum_bad;
  logic [LEN_W-1:0] taken_inc;

  assign accept    = in_valid && in_ready;
  assign too_long  = in_rx_byte > 8'(MAX_PAYLOAD);
  assign sum_bad   = in_rx_byte != xor_r;
  assign taken_inc = taken_r + LEN_W'(1);

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      unique case (phase_r)
        PH_HUNT:  if (in_rx_byte == sync_r) phase_nxt = PH_LEN;
        PH_LEN:   phase_nxt = too_long ? PH_HUNT : PH_ID;
        PH_ID:    phase_nxt = (len_r == '0) ? PH_CHECK : PH_DATA;
        PH_DATA:  if (taken_inc >= len_r) phase_nxt = PH_CHECK;
        PH_CHECK: phase_nxt = PH_HUNT;
        default:  phase_nxt = PH_HUNT;
      endcase
    end
  end

  // Handshake, outcome and payload write
  always_comb begin
    in_ready    = 1'b1;
    cmd_push    = 1'b0;
    cmd.status  = ST_DATA;
    cmd.id      = id_r;
    cmd.plen    = len_r[5:0];
    cmd.len     = len_r;
    cmd.bank    = wbank_r;
    ram_we      = 1'b0;
    ram_waddr   = {wbank_r, taken_r[AW-1:0]};
    ram_wdata   = in_rx_byte;
    unique case (phase_r)
      PH_LEN: begin
        in_ready = !q_stat.full;
        cmd_push = accept && too_long;
        cmd.status = ST_TOOLONG;
        cmd.id     = '0;
        cmd.plen   = (in_rx_byte > LEN_SAT_BYTE) ? PLEN_SAT : in_rx_byte[5:0];
        cmd.len    = '0;
      end
      PH_DATA: begin
        in_ready = !busy_r[wbank_r];
        ram_we   = accept;
      end
      PH_CHECK: begin
        in_ready = !q_stat.full;
        cmd_push = accept;
        priority if (sum_bad) begin
          cmd.status = ST_BADSUM;
        end else if (len_r == '0) begin
          cmd.status = ST_EMPTY;
        end else begin
          cmd.status = ST_DATA;
        end
      end
      default: begin
        in_ready = 1'b1;
      end
    endcase
  end

  // Bank occupancy: free after the last read, claim on a good frame
  always_comb begin
    busy_nxt = busy_r;
    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end
    if (cmd_push && cmd.status == ST_DATA) begin
      busy_nxt[wbank_r] = 1'b1;
    end
  end

  // Phase and bank bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      sync_r  <= SYNC_RESET;
      wbank_r <= 1'b0;
      busy_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      busy_r  <= busy_nxt;
      if (cfg_valid) begin
        sync_r <= cfg_sync_value;
      end
      if (cmd_push && cmd.status == ST_DATA) begin
        wbank_r <= !wbank_r;
      end
    end
  end

  // Frame fields and running XOR
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xor_r   <= '0;
      id_r    <= '0;
      len_r   <= '0;
      taken_r <= '0;
    end else if (accept) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (in_rx_byte == sync_r) xor_r <= in_rx_byte;
        end
        PH_LEN: begin
          if (!too_long) begin
            len_r <= LEN_W'(in_rx_byte);
            xor_r <= xor_r ^ in_rx_byte;
          end
        end
        PH_ID: begin
          id_r    <= in_rx_byte;
          xor_r   <= xor_r ^ in_rx_byte;
          taken_r <= '0;
        end
        PH_DATA: begin
          xor_r   <= xor_r ^ in_rx_byte;
          taken_r <= taken_inc;
        end
        default: begin
        end
      endcase
    end
  end

  // Checks
  `SLD_ASSERT_NEXT(a_check_to_hunt, accept && phase_r == PH_CHECK, phase_r == PH_HUNT, "check beat did not return to hunt")
  `SLD_ASSERT_IMPL(a_write_free_bank, ram_we, !busy_r[wbank_r], "payload write into a busy bank")

endmodule

// ===== src/sld_cmd_q.sv =====
// ----------------------------------------------------------------------------
// sld_cmd_q
// Two-entry queue of frame outcomes between the parser and the output side.
// ----------------------------------------------------------------------------
`include "sync_length_xor_deframer_macros.svh"

module sld_cmd_q (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sld_pkg::cmd_t      push_cmd,
  input  logic               pop,
  output sld_pkg::cmd_t      head,
  output sld_pkg::q_stat_t   stat
);

  import sld_pkg::*;

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wp_r;
  logic [PW-1:0] rp_r;
  logic [CW-1:0] cnt_r;

  assign head       = mem_r[rp_r];
  assign stat.full  = cnt_r == CW'(DEPTH);
  assign stat.empty = cnt_r == '0;

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + PW'(1);
      if (pop)  rp_r <= rp_r + PW'(1);
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + CW'(1);
        2'b01:   cnt_r <= cnt_r - CW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // Checks
  `SLD_ASSERT_IMPL(a_no_overflow, push, !stat.full || pop, "push into full outcome queue")
  `SLD_ASSERT_IMPL(a_no_underflow, pop, !stat.empty, "pop from empty outcome queue")

endmodule

// ===== src/sld_back.sv =====
// ----------------------------------------------------------------------------
// sld_back
// Output side: expands each frame outcome into result beats, reading
// payload bytes from the RAM through a two-stage stall-together pipeline.
// ----------------------------------------------------------------------------
`include "sync_length_xor_deframer_macros.svh"

module sld_back #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sld_pkg::cmd_t                   head,
  input  sld_pkg::q_stat_t                q_stat,
  output logic                            pop,
  output sld_pkg::bank_rel_t              rel,
  output logic                            ram_re,
  output logic [$clog2(MAX_PAYLOAD):0]    ram_raddr,
  input  logic [7:0]                      ram_rdata,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_status,
  output logic [7:0]                      out_message_id,
  output logic [5:0]                      out_payload_length,
  output logic [4:0]                      out_byte_index,
  output logic [7:0]                      out_payload_byte,
  output logic                            out_last
);

  import sld_pkg::*;

  localparam int AW = $clog2(MAX_PAYLOAD);

  logic [AW-1:0] idx_r;

  // Read stage
  logic          s1_v_r;
  logic          s1_data_r;
  status_t       s1_status_r;
  logic [7:0]    s1_id_r;
  logic [5:0]    s1_plen_r;
  logic [4:0]    s1_idx_r;
  logic          s1_last_r;

  // Output register
  logic          out_valid_r;
  status_t       out_status_r;
  logic [7:0]    out_id_r;
  logic [5:0]    out_plen_r;
  logic [4:0]    out_idx_r;
  logic [7:0]    out_byte_r;
  logic          out_last_r;

  logic advance;
  logic issue;
  logic is_data;
  logic last_item;

  assign advance   = !out_valid_r || out_ready;
  assign issue     = advance && !q_stat.empty;
  assign is_data   = head.status == ST_DATA;
  assign last_item = !is_data || (LEN_W'(idx_r) + LEN_W'(1) == head.len);
  assign pop       = issue && last_item;

  assign rel.valid = pop && is_data;
  assign rel.bank  = head.bank;

  assign ram_re    = issue && is_data;
  assign ram_raddr = {head.bank, idx_r};

  // Step through the payload of the head outcome
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (issue && is_data) begin
      idx_r <= last_item ? '0 : idx_r + AW'(1);
    end
  end

  // Read stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (advance) begin
      s1_v_r <= issue;
    end
  end

  // Read stage fields
  always_ff @(posedge clk) begin
    if (issue) begin
      s1_data_r   <= is_data;
      s1_status_r <= head.status;
      s1_id_r     <= head.id;
      s1_plen_r   <= head.plen;
      s1_idx_r    <= is_data ? 5'(idx_r) : 5'd0;
      s1_last_r   <= last_item;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_v_r;
    end
  end

  // Output fields, zero data on status results
  always_ff @(posedge clk) begin
    if (advance && s1_v_r) begin
      out_status_r <= s1_status_r;
      out_id_r     <= s1_id_r;
      out_plen_r   <= s1_plen_r;
      out_idx_r    <= s1_idx_r;
      out_byte_r   <= s1_data_r ? ram_rdata : 8'd0;
      out_last_r   <= s1_last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_message_id     = out_id_r;
  assign out_payload_length = out_plen_r;
  assign out_byte_index     = out_idx_r;
  assign out_payload_byte   = out_byte_r;
  assign out_last           = out_last_r;

  // Checks
  `SLD_ASSERT_NEXT(a_stall_holds_s1, s1_v_r && !advance, s1_v_r, "read stage lost a beat under stall")
  `SLD_ASSERT_IMPL(a_release_on_last, rel.valid, last_item && is_data, "bank released before last read")

endmodule

// ===== src/sync_length_xor_deframer.sv =====
// ----------------------------------------------------------------------------
// sync_length_xor_deframer
// Sync / length / id / XOR-checksum deframer for a received byte stream.
// ----------------------------------------------------------------------------
// Use:
//   in_*   : one received byte per beat (valid/ready).
//   out_*  : result beats (valid/ready): payload bytes tagged with id, length,
//            index and last, or one status beat per empty or failed frame.
//   cfg_*  : write of the sync byte value; always ready, write only when idle.
// Throughput: one input byte per cycle, set by the parser stepping one byte a
//   cycle. Results drain at one beat per cycle while the receiver is ready,
//   through the single RAM read port. Payload sits in two RAM banks, so one
//   frame drains while the next is received; input stalls only when both
//   banks still hold undelivered payload, or when the two-entry outcome
//   queue is full at a length or check byte.
// Result path: once a frame's check byte (or over-long length byte) is taken,
//   its outcome passes the outcome queue, read stage and output register.
// Receiver stall: results hold in the output register; the parser keeps
//   taking bytes until the limits above.
// Reset: synchronous rst_n; parser returns to hunting, sync value to 164,
//   queue and pipeline empty. Payload RAM is not cleared.
// ----------------------------------------------------------------------------
module sync_length_xor_deframer #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_sync_value,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [7:0] out_message_id,
  output logic [5:0] out_payload_length,
  output logic [4:0] out_byte_index,
  output logic [7:0] out_payload_byte,
  output logic       out_last
);

  import sld_pkg::*;

  localparam int AW = $clog2(MAX_PAYLOAD);

  logic          cmd_push;
  cmd_t          push_cmd;
  cmd_t          head;
  q_stat_t       q_stat;
  logic          pop;
  bank_rel_t     rel;
  logic          ram_we;
  logic [AW:0]   ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW:0]   ram_raddr;
  logic [7:0]    ram_rdata;

  assign cfg_ready = 1'b1;

  sld_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_sync_value (cfg_sync_value),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .cmd_push       (cmd_push),
    .cmd            (push_cmd),
    .q_stat         (q_stat),
    .rel            (rel),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata)
  );

  sld_cmd_q u_cmd_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  sld_ram #(.WIDTH(8), .DEPTH(2 ** (AW + 1))) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sld_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .q_stat             (q_stat),
    .pop                (pop),
    .rel                (rel),
    .ram_re             (ram_re),
    .ram_raddr          (ram_raddr),
    .ram_rdata          (ram_rdata),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_message_id     (out_message_id),
    .out_payload_length (out_payload_length),
    .out_byte_index     (out_byte_index),
    .out_payload_byte   (out_payload_byte),
    .out_last           (out_last)
  );

endmodule

// ===== dv/sync_length_xor_deframer_checker.sv =====
// ----------------------------------------------------------------------------
// sync_length_xor_deframer_checker
// Watches the config, byte and result channels of the deframer. Runs its own
// frame parser on every accepted byte, queues the results each frame should
// produce, and compares every result beat against the oldest queued one.
// ----------------------------------------------------------------------------
module sync_length_xor_deframer_checker #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [7:0] cfg_sync_value,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [1:0] out_status,
  input  logic [7:0] out_message_id,
  input  logic [5:0] out_payload_length,
  input  logic [4:0] out_byte_index,
  input  logic [7:0] out_payload_byte,
  input  logic       out_last,
  output int         mismatches,
  output int         outstanding
);

  import sld_pkg::*;

  typedef struct packed {
    status_t    status;
    logic [7:0] id;
    logic [5:0] plen;
    logic [4:0] idx;
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  frame_beat_t pending_beats[$];

  // Parser mirror
  logic [7:0] sync_byte;
  phase_t     parse_phase;
  logic [5:0] frame_len;
  logic [7:0] frame_tag;
  logic [7:0] xor_acc;
  logic [5:0] taken;
  logic [7:0] held_payload [MAX_PAYLOAD];
  int         fail_tally = 0;

  assign mismatches = fail_tally;

  function automatic frame_beat_t make_beat(status_t st, logic [7:0] id, logic [5:0] plen,
                                            logic [4:0] idx, logic [7:0] data, logic lst);
    frame_beat_t b;
    b.status = st;
    b.id     = id;
    b.plen   = plen;
    b.idx    = idx;
    b.data   = data;
    b.last   = lst;
    return b;
  endfunction

  // Advance the parser by one received byte and queue what it yields.
  task automatic absorb_byte(input logic [7:0] b);
    int i;
    case (parse_phase)
      PH_HUNT: begin
        if (b == sync_byte) begin
          xor_acc     = b;
          parse_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        if (b > MAX_PAYLOAD) begin
          pending_beats.push_back(make_beat(ST_TOOLONG, 8'd0,
                                            (b > LEN_SAT_BYTE) ? PLEN_SAT : b[5:0],
                                            5'd0, 8'd0, 1'b1));
          parse_phase = PH_HUNT;
        end else begin
          frame_len   = b[5:0];
          xor_acc     = xor_acc ^ b;
          parse_phase = PH_ID;
        end
      end
      PH_ID: begin
        frame_tag = b;
        xor_acc   = xor_acc ^ b;
        taken     = 6'd0;
        if (frame_len == 6'd0) parse_phase = PH_CHECK;
        else parse_phase = PH_DATA;
      end
      PH_DATA: begin
        if (taken < MAX_PAYLOAD) held_payload[taken] = b;
        xor_acc = xor_acc ^ b;
        taken   = taken + 6'd1;
        if (taken >= frame_len) parse_phase = PH_CHECK;
      end
      PH_CHECK: begin
        if (b != xor_acc) begin
          pending_beats.push_back(make_beat(ST_BADSUM, frame_tag, frame_len,
                                            5'd0, 8'd0, 1'b1));
        end else if (frame_len == 6'd0) begin
          pending_beats.push_back(make_beat(ST_EMPTY, frame_tag, 6'd0, 5'd0, 8'd0, 1'b1));
        end else begin
          for (i = 0; i < frame_len && i < MAX_PAYLOAD; i++) begin
            pending_beats.push_back(make_beat(ST_DATA, frame_tag, frame_len, i[4:0],
                                              held_payload[i], (i + 1 == frame_len)));
          end
        end
        parse_phase = PH_HUNT;
      end
      default: parse_phase = PH_HUNT;
    endcase
  endtask

  // Compare one result beat with the oldest queued one.
  task automatic compare_beat(input frame_beat_t got);
    frame_beat_t want;
    if (pending_beats.size() == 0) begin
      fail_tally++;
      $display("%0t: unexpected result: expected none, actual st=%0d id=%02h len=%0d idx=%0d data=%02h last=%0d",
               $time, got.status, got.id, got.plen, got.idx, got.data, got.last);
      return;
    end
    want = pending_beats.pop_front();
    if (got !== want) begin
      fail_tally++;
      $display("%0t: result mismatch: expected st=%0d id=%02h len=%0d idx=%0d data=%02h last=%0d, actual st=%0d id=%02h len=%0d idx=%0d data=%02h last=%0d",
               $time, want.status, want.id, want.plen, want.idx, want.data, want.last,
               got.status, got.id, got.plen, got.idx, got.data, got.last);
    end
  endtask

  // Sample all channels at the clock edge
  always @(posedge clk) begin
    if (!rst_n) begin
      sync_byte   = SYNC_RESET;
      parse_phase = PH_HUNT;
      frame_len   = 6'd0;
      frame_tag   = 8'd0;
      xor_acc     = 8'd0;
      taken       = 6'd0;
      pending_beats.delete();
    end else begin
      if (cfg_valid && cfg_ready) sync_byte = cfg_sync_value;
      if (in_valid && in_ready) absorb_byte(in_rx_byte);
      if (out_valid && out_ready)
        compare_beat({out_status, out_message_id, out_payload_length, out_byte_index,
                      out_payload_byte, out_last});
    end
    outstanding <= pending_beats.size();
  end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives received bytes and sync value writes into the deframer under random
// sender gaps and receiver stalls: a few directed frames first, then mostly
// well-formed random frames mixed with corrupted, over-long, cut-short frames
// and line noise. A checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;
  import sld_pkg::*;

  localparam int MAX_PAYLOAD  = 32;
  localparam int LIMIT_CYCLES = 200000;
  localparam int SETTLE       = 8;
  localparam int PHASE_BYTES  = 95;

  logic       clk;
  logic       rst_n;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_sync_value;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] out_status;
  logic [7:0] out_message_id;
  logic [5:0] out_payload_length;
  logic [4:0] out_byte_index;
  logic [7:0] out_payload_byte;
  logic       out_last;

  int         mismatches;
  int         outstanding;
  int         send_idle_pct;
  int         recv_stall_pct;
  int         bytes_sent;
  logic [7:0] cur_sync;
  logic [7:0] frame_buf [MAX_PAYLOAD];

  sync_length_xor_deframer #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_sync_value    (cfg_sync_value),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_message_id    (out_message_id),
    .out_payload_length(out_payload_length),
    .out_byte_index    (out_byte_index),
    .out_payload_byte  (out_payload_byte),
    .out_last          (out_last)
  );

  sync_length_xor_deframer_checker #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) frame_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_sync_value    (cfg_sync_value),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_message_id    (out_message_id),
    .out_payload_length(out_payload_length),
    .out_byte_index    (out_byte_index),
    .out_payload_byte  (out_payload_byte),
    .out_last          (out_last),
    .mismatches        (mismatches),
    .outstanding       (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop if the run hangs
  initial begin
    #(12 * LIMIT_CYCLES);
    $display("testbench: FAIL");
    $finish;
  end

  // Stall the result channel at random
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one byte beat after a random gap and hold it until accepted.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // Send sync, length, id, payload from frame_buf and the XOR check byte.
  task automatic send_frame(input logic [7:0] id, input logic [7:0] len, input bit corrupt);
    logic [7:0] chk;
    int i;
    send_byte(cur_sync);
    send_byte(len);
    if (len > MAX_PAYLOAD) return;
    chk = cur_sync ^ len ^ id;
    send_byte(id);
    for (i = 0; i < len; i++) begin
      send_byte(frame_buf[i]);
      chk = chk ^ frame_buf[i];
    end
    if (corrupt) chk = chk ^ 8'($urandom_range(255, 1));
    send_byte(chk);
  endtask

  task automatic write_sync(input logic [7:0] v);
    cfg_sync_value <= v;
    cfg_valid      <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_sync   = v;
  endtask

  // Stop sending, wait for every queued result, then let the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Mostly good frames with random content, plus broken frames and noise.
  task automatic run_traffic(input int budget);
    int start;
    int pick;
    int i;
    logic [7:0] len;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      pick = $urandom_range(99);
      if ($urandom_range(99) < 60) len = 8'($urandom_range(6));
      else if ($urandom_range(99) < 70) len = 8'($urandom_range(31, 7));
      else len = 8'(MAX_PAYLOAD);
      for (i = 0; i < MAX_PAYLOAD; i++) frame_buf[i] = 8'($urandom_range(255));
      if (pick < 60) begin
        send_frame(8'($urandom_range(255)), len, 1'b0);
      end else if (pick < 75) begin
        send_frame(8'($urandom_range(255)), len, 1'b1);
      end else if (pick < 85) begin
        send_frame(8'($urandom_range(255)), 8'($urandom_range(255, MAX_PAYLOAD + 1)), 1'b0);
      end else if (pick < 93) begin
        // cut the frame short; whatever follows gets parsed as its tail
        send_byte(cur_sync);
        send_byte(8'($urandom_range(8, 1)));
        send_byte(8'($urandom_range(255)));
        repeat ($urandom_range(2)) send_byte(8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_rx_byte     <= 8'd0;
    cfg_valid      <= 1'b0;
    cfg_sync_value <= 8'd0;
    cur_sync        = SYNC_RESET;
    bytes_sent      = 0;
    send_idle_pct   = 25;
    recv_stall_pct  = 60;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames on the reset sync value
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(8'h5A, 8'd0, 1'b0);
    frame_buf[0] = 8'hFF;
    frame_buf[1] = 8'h00;
    send_frame(8'hFF, 8'd2, 1'b0);
    send_frame(8'h00, 8'(MAX_PAYLOAD + 1), 1'b0);
    send_frame(8'h00, 8'hFF, 1'b0);
    send_frame(8'h22, 8'd0, 1'b1);
    frame_buf[0] = 8'h81;
    send_frame(8'h3C, 8'd1, 1'b1);
    drain();

    // Slow receiver
    write_sync(8'hFF);
    run_traffic(PHASE_BYTES);
    drain();

    // Slow sender
    send_idle_pct  = 60;
    recv_stall_pct = 25;
    write_sync(8'h00);
    run_traffic(PHASE_BYTES);
    drain();

    // Full rate both sides
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_sync(8'($urandom_range(255)));
    run_traffic(PHASE_BYTES);
    drain();

    if (mismatches == 0 && outstanding == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
